FILE: design/sse_pkg.sv
package sse_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC = 14;
	localparam int QDEPTH = 8;
	localparam int QPTR = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		REG_ROW_X = 3'd0,
		REG_ROW_Y = 3'd1,
		REG_ROW_Z = 3'd2,
		REG_LIGHT = 3'd3,
		REG_SHADOW = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] end_a_x;
		logic signed [COORD_BITS-1:0] end_a_y;
		logic signed [COORD_BITS-1:0] end_a_z;
		logic signed [COORD_BITS-1:0] end_b_x;
		logic signed [COORD_BITS-1:0] end_b_y;
		logic signed [COORD_BITS-1:0] end_b_z;
		logic signed [15:0] face_one_nx;
		logic signed [15:0] face_one_ny;
		logic signed [15:0] face_one_nz;
		logic signed [15:0] face_two_nx;
		logic signed [15:0] face_two_ny;
		logic signed [15:0] face_two_nz;
	} edge_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] corner0_x;
		logic signed [COORD_BITS-1:0] corner0_y;
		logic signed [COORD_BITS-1:0] corner0_z;
		logic signed [COORD_BITS-1:0] corner1_x;
		logic signed [COORD_BITS-1:0] corner1_y;
		logic signed [COORD_BITS-1:0] corner1_z;
		logic signed [COORD_BITS-1:0] corner2_x;
		logic signed [COORD_BITS-1:0] corner2_y;
		logic signed [COORD_BITS-1:0] corner2_z;
		logic signed [COORD_BITS-1:0] corner3_x;
		logic signed [COORD_BITS-1:0] corner3_y;
		logic signed [COORD_BITS-1:0] corner3_z;
	} quad_t;

	// silhouette edge, endpoints already swapped so first = corner0
	typedef struct packed {
		logic signed [COORD_BITS-1:0] p0_x;
		logic signed [COORD_BITS-1:0] p0_y;
		logic signed [COORD_BITS-1:0] p0_z;
		logic signed [COORD_BITS-1:0] p1_x;
		logic signed [COORD_BITS-1:0] p1_y;
		logic signed [COORD_BITS-1:0] p1_z;
	} sil_t;

	typedef struct packed {
		logic [63:0] row_x;
		logic [63:0] row_y;
		logic [63:0] row_z;
		logic [47:0] light;
		logic [14:0] shadow;
	} cfg_t;

	localparam int WW = COORD_BITS + 24; // world accumulator width

	// round Q.14 to Q.0 and clamp to COORD_BITS
	function automatic logic signed [COORD_BITS-1:0] round_sat(input logic signed [WW-1:0] v);
		logic signed [WW-1:0] r;
		logic signed [WW-1:0] hi;
		logic signed [WW-1:0] lo;
		r = (v + WW'(signed'(1 << (FRAC - 1)))) >>> FRAC;
		hi = WW'((64'sd1 <<< (COORD_BITS - 1)) - 1);
		lo = -hi - WW'(1);
		if (r > hi) return hi[COORD_BITS-1:0];
		else if (r < lo) return lo[COORD_BITS-1:0];
		else return r[COORD_BITS-1:0];
	endfunction

endpackage

FILE: design/shadow_silhouette_extruder.sv
// Shadow volume silhouette extruder for a directional light. Push one mesh
// edge per beat (endpoints, two face normals); an edge whose faces see the
// light with strictly opposite signs produces one quad beat on the output
// queue, other edges produce nothing. Throughput is one edge per cycle while
// full is low; a quad is ready once the edge that makes it has passed three
// classify registers, one queue write, and two transform stages plus the
// output register. An eight-entry queue sits between the two pipes and the
// output stage holds the last quad, so full rises only when the queue plus
// the classify pipe could hold no more edges, which happens only after the
// consumer stops popping. Write registers only while idle.
module shadow_silhouette_extruder (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input sse_pkg::edge_t in_data,
	output logic empty,
	input logic pop,
	output sse_pkg::quad_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data
);
	import sse_pkg::*;

	cfg_t cfg_q;
	logic f_valid;
	sil_t f_sil;
	logic q_ne;
	logic [QPTR:0] q_level;
	sil_t q_data;
	logic b_valid;
	quad_t b_quad;
	logic b_stall;
	logic q_rd;
	logic out_v_q;
	logic acc_s1;
	logic acc_s2;
	logic [QPTR+1:0] occ;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_x <= 64'h4000_0000_0000_0000;
			cfg_q.row_y <= 64'h0000_4000_0000_0000;
			cfg_q.row_z <= 64'h0000_0000_4000_0000;
			cfg_q.light <= 48'h0000_C000_0000;
			cfg_q.shadow <= 15'd5120;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW_X: cfg_q.row_x <= cfg_data;
				REG_ROW_Y: cfg_q.row_y <= cfg_data;
				REG_ROW_Z: cfg_q.row_z <= cfg_data;
				REG_LIGHT: cfg_q.light <= cfg_data[47:0];
				REG_SHADOW: cfg_q.shadow <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// front never stalls; track its first two stages so full can count every
	// edge that may still land in the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
			acc_s2 <= 1'b0;
		end else begin
			acc_s1 <= push && !full;
			acc_s2 <= acc_s1;
		end
	end

	// hold input once queue entries plus classify beats fill the queue
	assign occ = (QPTR+2)'(q_level) + (QPTR+2)'(acc_s1) + (QPTR+2)'(acc_s2)
		+ (QPTR+2)'(f_valid);
	assign full = occ >= (QPTR+2)'(QDEPTH);

	sse_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(push && !full), .in_edge(in_data),
		.cfg(cfg_q), .stall(1'b0), .out_valid(f_valid), .out_sil(f_sil)
	);

	// back pipeline: advance unless its final result waits unpopped
	assign b_stall = out_v_q && !pop;
	assign q_rd = q_ne && !b_stall;

	sse_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(f_valid), .wdata(f_sil), .rd(q_rd),
		.nonempty(q_ne), .level(q_level), .rdata(q_data)
	);

	sse_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_rd), .in_sil(q_data), .cfg(cfg_q),
		.stall(b_stall), .out_valid(b_valid), .out_quad(b_quad)
	);

	assign out_v_q = b_valid;
	assign out_data = b_quad;
	assign empty = !out_v_q;

endmodule

FILE: design/sse_front.sv
module sse_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input sse_pkg::edge_t in_edge,
	input sse_pkg::cfg_t cfg,
	input logic stall,
	output logic out_valid,
	output sse_pkg::sil_t out_sil
);
	import sse_pkg::*;

	// stage 1: rotated light L = R^T D (exact, Q6.28)
	logic signed [33:0] lt_c [3];
	logic signed [33:0] lt_s1 [3];
	logic signed [15:0] rm [3][3];
	logic signed [15:0] dv [3];
	edge_t e_s1;
	logic v_s1;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rm[0][c] = cfg.row_x[63-16*c -: 16];
			rm[1][c] = cfg.row_y[63-16*c -: 16];
			rm[2][c] = cfg.row_z[63-16*c -: 16];
			dv[c] = cfg.light[47-16*c -: 16];
		end
		for (int j = 0; j < 3; j++)
			lt_c[j] = 34'(rm[0][j] * dv[0]) + 34'(rm[1][j] * dv[1]) + 34'(rm[2][j] * dv[2]);
	end

	// stage 2: per-component products
	logic signed [49:0] p1_s2 [3];
	logic signed [49:0] p2_s2 [3];
	edge_t e_s2;
	logic v_s2;

	// stage 3: sums and classification
	logic signed [51:0] d1;
	logic signed [51:0] d2;
	logic one_lit;
	logic two_lit;

	always_comb begin
		d1 = 52'(p1_s2[0]) + 52'(p1_s2[1]) + 52'(p1_s2[2]);
		d2 = 52'(p2_s2[0]) + 52'(p2_s2[1]) + 52'(p2_s2[2]);
		one_lit = (d1 > 0) && (d2 < 0);
		two_lit = (d1 < 0) && (d2 > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (!stall) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2 && (one_lit || two_lit);
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			e_s1 <= in_edge;
			lt_s1 <= lt_c;
			e_s2 <= e_s1;
			p1_s2[0] <= lt_s1[0] * e_s1.face_one_nx;
			p1_s2[1] <= lt_s1[1] * e_s1.face_one_ny;
			p1_s2[2] <= lt_s1[2] * e_s1.face_one_nz;
			p2_s2[0] <= lt_s1[0] * e_s1.face_two_nx;
			p2_s2[1] <= lt_s1[1] * e_s1.face_two_ny;
			p2_s2[2] <= lt_s1[2] * e_s1.face_two_nz;
			if (one_lit) begin
				out_sil <= '{e_s2.end_b_x, e_s2.end_b_y, e_s2.end_b_z,
					e_s2.end_a_x, e_s2.end_a_y, e_s2.end_a_z};
			end else begin
				out_sil <= '{e_s2.end_a_x, e_s2.end_a_y, e_s2.end_a_z,
					e_s2.end_b_x, e_s2.end_b_y, e_s2.end_b_z};
			end
		end
	end

endmodule

FILE: design/sse_queue.sv
module sse_queue (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input sse_pkg::sil_t wdata,
	input logic rd,
	output logic nonempty,
	output logic [sse_pkg::QPTR:0] level,
	output sse_pkg::sil_t rdata
);
	import sse_pkg::*;

	sil_t mem_q [QDEPTH];
	logic [QPTR-1:0] wp_q;
	logic [QPTR-1:0] rp_q;
	logic [QPTR:0] cnt_q;

	assign nonempty = cnt_q != '0;
	assign rdata = mem_q[rp_q];
	assign level = cnt_q;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR+1)'(wr) - (QPTR+1)'(rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(rd && !nonempty))
		else $error("queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n) !(wr && cnt_q == (QPTR+1)'(QDEPTH) && !rd))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (QPTR+1)'(QDEPTH))
		else $error("queue count out of range");

endmodule

FILE: design/sse_back.sv
module sse_back (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input sse_pkg::sil_t in_sil,
	input sse_pkg::cfg_t cfg,
	input logic stall,
	output logic out_valid,
	output sse_pkg::quad_t out_quad
);
	import sse_pkg::*;

	logic signed [15:0] rm [3][3];
	logic signed [15:0] tr [3];
	logic signed [15:0] dv [3];
	logic signed [COORD_BITS-1:0] pa [3];
	logic signed [COORD_BITS-1:0] pb [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rm[0][c] = cfg.row_x[63-16*c -: 16];
			rm[1][c] = cfg.row_y[63-16*c -: 16];
			rm[2][c] = cfg.row_z[63-16*c -: 16];
			dv[c] = cfg.light[47-16*c -: 16];
		end
		tr[0] = cfg.row_x[15:0];
		tr[1] = cfg.row_y[15:0];
		tr[2] = cfg.row_z[15:0];
		pa = '{in_sil.p0_x, in_sil.p0_y, in_sil.p0_z};
		pb = '{in_sil.p1_x, in_sil.p1_y, in_sil.p1_z};
	end

	// stage 1: products
	logic signed [WW-1:0] ma_s1 [3][3];
	logic signed [WW-1:0] mb_s1 [3][3];
	logic signed [WW-1:0] tr_s1 [3];
	logic v_s1;
	// stage 2: world corners
	logic signed [COORD_BITS-1:0] w0_s2 [3];
	logic signed [COORD_BITS-1:0] w1_s2 [3];
	logic signed [WW-1:0] off_s2 [3];
	logic v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (!stall) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					ma_s1[r][c] <= WW'(rm[r][c] * pa[c]);
					mb_s1[r][c] <= WW'(rm[r][c] * pb[c]);
				end
				tr_s1[r] <= WW'(tr[r]) <<< FRAC;
			end
			for (int r = 0; r < 3; r++) begin
				// rotated point plus translation, both in Q.14
				w0_s2[r] <= round_sat(ma_s1[r][0] + ma_s1[r][1] + ma_s1[r][2]
					+ tr_s1[r]);
				w1_s2[r] <= round_sat(mb_s1[r][0] + mb_s1[r][1] + mb_s1[r][2]
					+ tr_s1[r]);
				off_s2[r] <= WW'(dv[r] * $signed({1'b0, cfg.shadow}));
			end
			out_quad.corner0_x <= w0_s2[0];
			out_quad.corner0_y <= w0_s2[1];
			out_quad.corner0_z <= w0_s2[2];
			out_quad.corner1_x <= w1_s2[0];
			out_quad.corner1_y <= w1_s2[1];
			out_quad.corner1_z <= w1_s2[2];
			out_quad.corner2_x <= round_sat((WW'(w1_s2[0]) <<< FRAC) - off_s2[0]);
			out_quad.corner2_y <= round_sat((WW'(w1_s2[1]) <<< FRAC) - off_s2[1]);
			out_quad.corner2_z <= round_sat((WW'(w1_s2[2]) <<< FRAC) - off_s2[2]);
			out_quad.corner3_x <= round_sat((WW'(w0_s2[0]) <<< FRAC) - off_s2[0]);
			out_quad.corner3_y <= round_sat((WW'(w0_s2[1]) <<< FRAC) - off_s2[1]);
			out_quad.corner3_z <= round_sat((WW'(w0_s2[2]) <<< FRAC) - off_s2[2]);
		end
	end

endmodule

FILE: tb/sv/shadow_silhouette_extruder_tb.sv
`timescale 1ns / 1ps

module shadow_silhouette_extruder_tb;
	import sse_pkg::*;

	// Allow a margin for drains.
	localparam int DRAIN_CYCLES = 40;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	edge_t in_data = '0;
	logic empty;
	logic pop = 1'b0;
	quad_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// Shadow copy of the register file, used by the quad predictor.
	logic [63:0] row_reg [3];
	logic [47:0] light_reg;
	logic [14:0] shadow_reg;

	quad_t quad_queue [$];
	int error_count = 0;
	int quads_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	longint cycle_count = 0;

	shadow_silhouette_extruder uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_data(in_data),
		.empty(empty),
		.pop(pop),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Watchdog: end the run with a fail once the cycle counter reaches CYCLE_LIMIT.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("shadow_silhouette_extruder regression: fail");
			$finish;
		end
	end

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		error_count++;
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
	endtask

	// Round a Q.14 value to Q.0 to nearest (halves up) and clamp to the coordinate range.
	function automatic logic signed [15:0] round_clamp(input longint v);
		longint r;
		r = (v + (64'sd1 <<< 13)) >>> 14;
		if (r > 32767) r = 32767;
		else if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic longint rot_elem(input int r, input int c);
		logic signed [15:0] e;
		e = row_reg[r][63 - 16 * c -: 16];
		return longint'(e);
	endfunction

	function automatic longint light_comp(input int c);
		logic signed [15:0] e;
		e = light_reg[47 - 16 * c -: 16];
		return longint'(e);
	endfunction

	// Take an object-space point to world space (affine, w = 1).
	task automatic place_point(input longint p [3], output longint w [3]);
		longint acc;
		logic signed [15:0] t;
		for (int r = 0; r < 3; r++) begin
			t = row_reg[r][15:0];
			acc = longint'(t) <<< 14;
			for (int c = 0; c < 3; c++) acc += rot_elem(r, c) * p[c];
			w[r] = longint'(round_clamp(acc));
		end
	endtask

	// Work out the quad an edge produces, if it lies on the silhouette.
	task automatic predict_quad(input edge_t e);
		longint a [3], b [3], n1 [3], n2 [3], lo [3];
		longint c0 [3], c1 [3], w0 [3], w1 [3];
		longint dot1, dot2, off;
		quad_t q;
		a = '{longint'(e.end_a_x), longint'(e.end_a_y), longint'(e.end_a_z)};
		b = '{longint'(e.end_b_x), longint'(e.end_b_y), longint'(e.end_b_z)};
		n1 = '{longint'(e.face_one_nx), longint'(e.face_one_ny), longint'(e.face_one_nz)};
		n2 = '{longint'(e.face_two_nx), longint'(e.face_two_ny), longint'(e.face_two_nz)};
		dot1 = 0;
		dot2 = 0;
		// Light in object space: transposed rotation times world direction.
		for (int j = 0; j < 3; j++) begin
			lo[j] = 0;
			for (int i = 0; i < 3; i++) lo[j] += rot_elem(i, j) * light_comp(i);
			dot1 += lo[j] * n1[j];
			dot2 += lo[j] * n2[j];
		end
		if (dot1 > 0 && dot2 < 0) begin
			place_point(b, c0);
			place_point(a, c1);
		end else if (dot1 < 0 && dot2 > 0) begin
			place_point(a, c0);
			place_point(b, c1);
		end else begin
			return;
		end
		for (int i = 0; i < 3; i++) begin
			off = light_comp(i) * longint'(shadow_reg);
			w1[i] = longint'(round_clamp((c1[i] <<< 14) - off));
			w0[i] = longint'(round_clamp((c0[i] <<< 14) - off));
		end
		q.corner0_x = 16'(c0[0]); q.corner0_y = 16'(c0[1]); q.corner0_z = 16'(c0[2]);
		q.corner1_x = 16'(c1[0]); q.corner1_y = 16'(c1[1]); q.corner1_z = 16'(c1[2]);
		q.corner2_x = 16'(w1[0]); q.corner2_y = 16'(w1[1]); q.corner2_z = 16'(w1[2]);
		q.corner3_x = 16'(w0[0]); q.corner3_y = 16'(w0[1]); q.corner3_z = 16'(w0[2]);
		quad_queue = {quad_queue, q};
	endtask

	// Receiver: stall at random, or hold off entirely during the pressure test.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check each accepted quad against the oldest prediction.
	always @(posedge clk) begin
		quad_t want;
		if (arst_n && pop && !empty) begin
			quads_seen++;
			if (quad_queue.size() == 0) begin
				report("unexpected quad", out_data[15:0], 16'h0);
			end else begin
				want = quad_queue.pop_front();
				if (out_data.corner0_x !== want.corner0_x) report("corner0_x", out_data.corner0_x, want.corner0_x);
				if (out_data.corner0_y !== want.corner0_y) report("corner0_y", out_data.corner0_y, want.corner0_y);
				if (out_data.corner0_z !== want.corner0_z) report("corner0_z", out_data.corner0_z, want.corner0_z);
				if (out_data.corner1_x !== want.corner1_x) report("corner1_x", out_data.corner1_x, want.corner1_x);
				if (out_data.corner1_y !== want.corner1_y) report("corner1_y", out_data.corner1_y, want.corner1_y);
				if (out_data.corner1_z !== want.corner1_z) report("corner1_z", out_data.corner1_z, want.corner1_z);
				if (out_data.corner2_x !== want.corner2_x) report("corner2_x", out_data.corner2_x, want.corner2_x);
				if (out_data.corner2_y !== want.corner2_y) report("corner2_y", out_data.corner2_y, want.corner2_y);
				if (out_data.corner2_z !== want.corner2_z) report("corner2_z", out_data.corner2_z, want.corner2_z);
				if (out_data.corner3_x !== want.corner3_x) report("corner3_x", out_data.corner3_x, want.corner3_x);
				if (out_data.corner3_y !== want.corner3_y) report("corner3_y", out_data.corner3_y, want.corner3_y);
				if (out_data.corner3_z !== want.corner3_z) report("corner3_z", out_data.corner3_z, want.corner3_z);
			end
		end
	end

	// Offer one edge, idling first at the current rate, and hold until accepted.
	task automatic send_edge(input edge_t e);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_data <= e;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_quad(e);
	endtask

	task automatic go_quiet();
		push <= 1'b0;
		while (quad_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register while the block is idle and mirror it.
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ROW_X: row_reg[0] = val;
			REG_ROW_Y: row_reg[1] = val;
			REG_ROW_Z: row_reg[2] = val;
			REG_LIGHT: light_reg = val[47:0];
			REG_SHADOW: shadow_reg = val[14:0];
			default: ;
		endcase
	endtask

	function automatic logic [15:0] pick16();
		case ($urandom_range(5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	// Random edge; mostly a pair of faces that straddle the light.
	function automatic edge_t random_edge();
		edge_t e;
		e = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		e.end_a_x = pick16(); e.end_a_y = pick16(); e.end_a_z = pick16();
		e.end_b_x = pick16(); e.end_b_y = pick16(); e.end_b_z = pick16();
		if ($urandom_range(3) != 0) begin
			// Second face normal faces roughly away from the first.
			e.face_two_nx = -e.face_one_nx + 16'($signed($urandom_range(64)) - 32);
			e.face_two_ny = -e.face_one_ny + 16'($signed($urandom_range(64)) - 32);
			e.face_two_nz = -e.face_one_nz + 16'($signed($urandom_range(64)) - 32);
		end
		return e;
	endfunction

	function automatic logic [63:0] random_row();
		return {$urandom, $urandom};
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) send_edge(random_edge());
	endtask

	task automatic test_defaults();
		edge_t e;
		// Face one lit under the default downward light (light -y).
		e = '0;
		e.end_a_x = 16'sh0100; e.end_b_z = -16'sh0200;
		e.face_one_ny = -16'sh4000; e.face_two_ny = 16'sh4000;
		send_edge(e);
		// Face two lit: swap the normals.
		e.face_one_ny = 16'sh4000; e.face_two_ny = -16'sh4000;
		send_edge(e);
		// Zero dot product: no quad.
		e.face_one_ny = 16'sh0000;
		send_edge(e);
		// Both faces lit: no quad.
		e.face_one_ny = -16'sh4000; e.face_two_ny = -16'sh2000;
		send_edge(e);
		// Zero normals.
		e.face_one_ny = 16'sh0000; e.face_two_ny = 16'sh0000;
		send_edge(e);
		// Extreme coordinates saturate on extrusion.
		e.end_a_x = 16'sh7FFF; e.end_a_y = 16'sh7FFF; e.end_a_z = 16'sh7FFF;
		e.end_b_x = -16'sh8000; e.end_b_y = -16'sh8000; e.end_b_z = -16'sh8000;
		e.face_one_ny = 16'sh7FFF; e.face_two_ny = -16'sh8000;
		send_edge(e);
		e.face_one_ny = -16'sh8000; e.face_two_ny = 16'sh7FFF;
		send_edge(e);
		e.face_one_nx = 16'sh7FFF; e.face_one_nz = -16'sh8000;
		e.face_two_nx = -16'sh8000; e.face_two_nz = 16'sh7FFF;
		send_edge(e);
		go_quiet();
	endtask

	task automatic test_extreme_config();
		// Full-scale rotation and translation, longest shadow.
		write_reg(REG_ROW_X, 64'h7FFF_8000_7FFF_7FFF);
		write_reg(REG_ROW_Y, 64'h8000_7FFF_8000_8000);
		write_reg(REG_ROW_Z, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_LIGHT, 64'hFFFF_7FFF_8000_0001);
		write_reg(REG_SHADOW, 64'h7FFF);
		for (int i = 0; i < 10; i++) send_edge(random_edge());
		go_quiet();
		// Zero light direction and zero shadow: never a silhouette.
		write_reg(REG_LIGHT, 64'h0);
		write_reg(REG_SHADOW, 64'h0);
		for (int i = 0; i < 5; i++) send_edge(random_edge());
		go_quiet();
	endtask

	task automatic test_random_phases();
		int idle [4] = '{0, 56, 0, 32};
		int stall [4] = '{0, 0, 56, 32};
		for (int p = 0; p < 4; p++) begin
			write_reg(REG_ROW_X, random_row());
			write_reg(REG_ROW_Y, random_row());
			write_reg(REG_ROW_Z, random_row());
			write_reg(REG_LIGHT, random_row());
			write_reg(REG_SHADOW, 64'($urandom));
			send_idle_pct = idle[p];
			recv_stall_pct = stall[p];
			run_random(370);
			go_quiet();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		// Identity transform so most edges become quads and fill the queue.
		write_reg(REG_ROW_X, 64'h4000_0000_0000_0000);
		write_reg(REG_ROW_Y, 64'h0000_4000_0000_0000);
		write_reg(REG_ROW_Z, 64'h0000_0000_4000_0000);
		write_reg(REG_LIGHT, 64'h0000_C000_0000);
		hold_off = 1'b1;
		fork
			begin
				int waited;
				waited = 0;
				while (waited < 300) begin
					@(posedge clk);
					waited++;
				end
				hold_off = 1'b0;
			end
			run_random(200);
		join
		go_quiet();
	endtask

	initial begin
		row_reg[0] = 64'd4611686018427387904;
		row_reg[1] = 64'd70368744177664;
		row_reg[2] = 64'd1073741824;
		light_reg = 48'd3221225472;
		shadow_reg = 15'd5120;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_extreme_config();
		test_backpressure();
		test_random_phases();
		go_quiet();
		if (error_count == 0)
			$display("shadow_silhouette_extruder regression: pass");
		else
			$display("shadow_silhouette_extruder regression: fail");
		$finish;
	end

endmodule

FILE: filelist.f
design/sse_pkg.sv
design/sse_front.sv
design/sse_queue.sv
design/sse_back.sv
design/shadow_silhouette_extruder.sv
tb/sv/shadow_silhouette_extruder_tb.sv
